>>> rtl/rrsp_pkg.sv
// shared constants, sine table and rounding helpers for the shadow projection block
package rrsp_pkg;

    localparam int KINV_Q30  = 652032875;
    localparam int EXT_BITS  = 8;
    localparam int VEC_SHIFT = 24;
    localparam int OUT_W     = 26;
    localparam int Q_DEPTH   = 8;

    localparam logic [2:0] REG_CENTER_X  = 3'd0;
    localparam logic [2:0] REG_CENTER_Y  = 3'd1;
    localparam logic [2:0] REG_WIDTH     = 3'd2;
    localparam logic [2:0] REG_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_ROTATION  = 3'd4;
    localparam logic [2:0] REG_EXTENSION = 3'd5;

    function automatic logic signed [16:0] sin_q15(logic [6:0] d);
        logic signed [16:0] r;
        case (d)
            7'd0: r = 17'sd0;      7'd1: r = 17'sd572;    7'd2: r = 17'sd1144;
            7'd3: r = 17'sd1715;   7'd4: r = 17'sd2286;   7'd5: r = 17'sd2856;
            7'd6: r = 17'sd3425;   7'd7: r = 17'sd3993;   7'd8: r = 17'sd4560;
            7'd9: r = 17'sd5126;   7'd10: r = 17'sd5690;  7'd11: r = 17'sd6252;
            7'd12: r = 17'sd6813;  7'd13: r = 17'sd7371;  7'd14: r = 17'sd7927;
            7'd15: r = 17'sd8481;  7'd16: r = 17'sd9032;  7'd17: r = 17'sd9580;
            7'd18: r = 17'sd10126; 7'd19: r = 17'sd10668; 7'd20: r = 17'sd11207;
            7'd21: r = 17'sd11743; 7'd22: r = 17'sd12275; 7'd23: r = 17'sd12803;
            7'd24: r = 17'sd13328; 7'd25: r = 17'sd13848; 7'd26: r = 17'sd14365;
            7'd27: r = 17'sd14876; 7'd28: r = 17'sd15384; 7'd29: r = 17'sd15886;
            7'd30: r = 17'sd16384; 7'd31: r = 17'sd16877; 7'd32: r = 17'sd17364;
            7'd33: r = 17'sd17847; 7'd34: r = 17'sd18324; 7'd35: r = 17'sd18795;
            7'd36: r = 17'sd19261; 7'd37: r = 17'sd19720; 7'd38: r = 17'sd20174;
            7'd39: r = 17'sd20622; 7'd40: r = 17'sd21063; 7'd41: r = 17'sd21498;
            7'd42: r = 17'sd21926; 7'd43: r = 17'sd22348; 7'd44: r = 17'sd22763;
            7'd45: r = 17'sd23170; 7'd46: r = 17'sd23571; 7'd47: r = 17'sd23965;
            7'd48: r = 17'sd24351; 7'd49: r = 17'sd24730; 7'd50: r = 17'sd25102;
            7'd51: r = 17'sd25466; 7'd52: r = 17'sd25822; 7'd53: r = 17'sd26170;
            7'd54: r = 17'sd26510; 7'd55: r = 17'sd26842; 7'd56: r = 17'sd27166;
            7'd57: r = 17'sd27482; 7'd58: r = 17'sd27789; 7'd59: r = 17'sd28088;
            7'd60: r = 17'sd28378; 7'd61: r = 17'sd28660; 7'd62: r = 17'sd28932;
            7'd63: r = 17'sd29197; 7'd64: r = 17'sd29452; 7'd65: r = 17'sd29698;
            7'd66: r = 17'sd29935; 7'd67: r = 17'sd30163; 7'd68: r = 17'sd30382;
            7'd69: r = 17'sd30592; 7'd70: r = 17'sd30792; 7'd71: r = 17'sd30983;
            7'd72: r = 17'sd31164; 7'd73: r = 17'sd31336; 7'd74: r = 17'sd31499;
            7'd75: r = 17'sd31651; 7'd76: r = 17'sd31795; 7'd77: r = 17'sd31928;
            7'd78: r = 17'sd32052; 7'd79: r = 17'sd32166; 7'd80: r = 17'sd32270;
            7'd81: r = 17'sd32365; 7'd82: r = 17'sd32449; 7'd83: r = 17'sd32524;
            7'd84: r = 17'sd32588; 7'd85: r = 17'sd32643; 7'd86: r = 17'sd32688;
            7'd87: r = 17'sd32723; 7'd88: r = 17'sd32748; 7'd89: r = 17'sd32763;
            7'd90: r = 17'sd32767;
            default: r = 17'sd0;
        endcase
        return r;
    endfunction

    // d in 0..359, quadrant folding onto the first-quadrant table
    function automatic logic signed [16:0] sin_deg(logic [8:0] d);
        logic signed [16:0] r;
        if (d <= 9'd90) begin
            r = sin_q15(d[6:0]);
        end else if (d <= 9'd180) begin
            r = sin_q15(7'(9'd180 - d));
        end else if (d <= 9'd270) begin
            r = -sin_q15(7'(d - 9'd180));
        end else begin
            r = -sin_q15(7'(9'd360 - d));
        end
        return r;
    endfunction

    // shift right, rounding half away from zero
    function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int unsigned sh);
        logic signed [63:0] half;
        logic signed [63:0] r;
        half = 64'sd1 <<< (sh - 1);
        if (sh == 0) begin
            r = v;
        end else if (v < 0) begin
            r = -((-v + half) >>> sh);
        end else begin
            r = (v + half) >>> sh;
        end
        return r;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(logic signed [63:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > $signed((64'sd1 <<< (OUT_W - 1)) - 64'sd1)) begin
            r = {1'b0, {(OUT_W - 1){1'b1}}};
        end else if (v < -$signed(64'sd1 <<< (OUT_W - 1))) begin
            r = {1'b1, {(OUT_W - 1){1'b0}}};
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/rrsp_queue.sv
// short fifo between the corner front end and the cordic back end
module rrsp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push_valid,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic                       out_valid,
    output logic [WIDTH-1:0]           out_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push_valid) - CNT_W'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (count_reg < CNT_W'(DEPTH)))
        else $error("queue written while full");

endmodule

>>> rtl/rrsp_front.sv
// front end: takes a light position and issues the four rotated corners as jobs
module rrsp_front #(
    parameter int FRAC_BITS = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [15:0]       s_light_x,
    input  logic signed [15:0]       s_light_y,
    input  logic signed [15:0]       center_x,
    input  logic signed [15:0]       center_y,
    input  logic [15:0]              rect_width,
    input  logic [15:0]              rect_height,
    input  logic [8:0]               rotation_deg,
    input  logic [19:0]              extension_length,
    input  logic [$clog2(rrsp_pkg::Q_DEPTH+1)-1:0] q_count,
    output logic                     push_valid,
    output logic [2*(20+FRAC_BITS)+2*(47+FRAC_BITS)+(31+FRAC_BITS)+3:0] push_data
);
    localparam int PW    = 20 + FRAC_BITS;
    localparam int VIW   = 21 + FRAC_BITS;
    localparam int VW    = 47 + FRAC_BITS;
    localparam int RW    = 31 + FRAC_BITS;
    localparam int CNT_W = $clog2(rrsp_pkg::Q_DEPTH + 1);

    logic              busy_reg;
    logic [1:0]        k_reg;
    logic signed [15:0] lx_reg, ly_reg;

    logic              v1_reg;
    logic [1:0]        k1_reg;
    logic signed [15:0] lx1_reg, ly1_reg;
    logic signed [16:0] s1_reg, c1_reg;

    logic              v2_reg;
    logic [1:0]        k2_reg;
    logic signed [15:0] lx2_reg, ly2_reg;
    logic signed [33:0] wc2_reg, ws2_reg, hc2_reg, hs2_reg;
    logic [49:0]       lp2_reg;

    logic              v3_reg;
    logic [1:0]        k3_reg;
    logic signed [15:0] lx3_reg, ly3_reg;
    logic signed [PW-1:0] px3_reg, py3_reg;
    logic signed [RW-1:0] rx3_reg;

    logic [8:0]        deg, deg90;
    logic              issue;
    logic [CNT_W:0]    used;

    logic              sx, sy;
    logic signed [34:0] tx, ty;
    logic signed [PW-1:0] px, py;
    logic signed [VIW-1:0] vx, vy, ax, ay;
    logic              zero, flip;
    logic signed [VW-1:0] big_x, big_y;
    logic signed [RW-1:0] rx0;

    assign used    = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(v1_reg) + (CNT_W + 1)'(v2_reg)
                   + (CNT_W + 1)'(v3_reg);
    assign issue   = busy_reg && (used < (CNT_W + 1)'(rrsp_pkg::Q_DEPTH));
    assign s_ready = !busy_reg || (issue && (k_reg == 2'd3));

    always_comb begin
        deg   = (rotation_deg >= 9'd360) ? rotation_deg - 9'd360 : rotation_deg;
        deg90 = deg + 9'd90;
        if (deg90 >= 9'd360) begin
            deg90 = deg90 - 9'd360;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end else begin
            if (issue) begin
                k_reg <= k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
            end
            if (s_valid && s_ready) begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            lx_reg <= s_light_x;
            ly_reg <= s_light_y;
        end
        k1_reg  <= k_reg;
        lx1_reg <= lx_reg;
        ly1_reg <= ly_reg;
        s1_reg  <= rrsp_pkg::sin_deg(deg);
        c1_reg  <= rrsp_pkg::sin_deg(deg90);

        k2_reg  <= k1_reg;
        lx2_reg <= lx1_reg;
        ly2_reg <= ly1_reg;
        wc2_reg <= $signed({1'b0, rect_width}) * c1_reg;
        ws2_reg <= $signed({1'b0, rect_width}) * s1_reg;
        hc2_reg <= $signed({1'b0, rect_height}) * c1_reg;
        hs2_reg <= $signed({1'b0, rect_height}) * s1_reg;
        lp2_reg <= 50'(extension_length) * 50'(rrsp_pkg::KINV_Q30);

        k3_reg  <= k2_reg;
        lx3_reg <= lx2_reg;
        ly3_reg <= ly2_reg;
        px3_reg <= px;
        py3_reg <= py;
        rx3_reg <= rx0;
    end

    // corner signs in strip order: (+,+) (-,+) (-,-) (+,-)
    always_comb begin
        sx = (k2_reg == 2'd0) || (k2_reg == 2'd3);
        sy = (k2_reg == 2'd0) || (k2_reg == 2'd1);
        tx = (sx ? 35'(wc2_reg) : -35'(wc2_reg)) - (sy ? 35'(hs2_reg) : -35'(hs2_reg));
        ty = (sx ? 35'(ws2_reg) : -35'(ws2_reg)) + (sy ? 35'(hc2_reg) : -35'(hc2_reg));
        px = PW'((64'(center_x) <<< FRAC_BITS)
             + rrsp_pkg::round_shift(64'(tx) <<< FRAC_BITS, 16));
        py = PW'((64'(center_y) <<< FRAC_BITS)
             + rrsp_pkg::round_shift(64'(ty) <<< FRAC_BITS, 16));
        rx0 = RW'(rrsp_pkg::round_shift($signed(64'(lp2_reg)) <<< FRAC_BITS,
                                        30 - rrsp_pkg::EXT_BITS));
    end

    always_comb begin
        vx = VIW'(px3_reg) - (VIW'(lx3_reg) <<< FRAC_BITS);
        vy = VIW'(py3_reg) - (VIW'(ly3_reg) <<< FRAC_BITS);
        zero  = (vx == '0) && (vy == '0);
        flip  = vx < 0;
        ax    = flip ? -vx : vx;
        ay    = flip ? -vy : vy;
        big_x = VW'(ax) <<< rrsp_pkg::VEC_SHIFT;
        big_y = VW'(ay) <<< rrsp_pkg::VEC_SHIFT;
    end

    assign push_valid = v3_reg;
    assign push_data  = {zero, flip, k3_reg, rx3_reg, big_y, big_x, py3_reg, px3_reg};

endmodule

>>> rtl/rrsp_back.sv
// back end: cordic pipeline that pushes each corner away from the light, then emits two vertices
module rrsp_back #(
    parameter int FRAC_BITS    = 4,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  logic [2*(20+FRAC_BITS)+2*(47+FRAC_BITS)+(31+FRAC_BITS)+3:0] q_data,
    output logic        q_pop,
    input  logic [19:0] extension_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [rrsp_pkg::OUT_W-1:0] m_vertex_x,
    output logic signed [rrsp_pkg::OUT_W-1:0] m_vertex_y,
    output logic [1:0]  m_corner,
    output logic        m_extended,
    output logic        m_last
);
    localparam int PW = 20 + FRAC_BITS;
    localparam int VW = 47 + FRAC_BITS;
    localparam int RW = 31 + FRAC_BITS;
    localparam int N  = CORDIC_STEPS;
    localparam int OW = rrsp_pkg::OUT_W;

    logic                 st_valid_reg [0:N];
    logic signed [VW-1:0] x_reg  [0:N];
    logic signed [VW-1:0] y_reg  [0:N];
    logic signed [RW-1:0] rx_reg [0:N];
    logic signed [RW-1:0] ry_reg [0:N];
    logic signed [PW-1:0] px_reg [0:N];
    logic signed [PW-1:0] py_reg [0:N];
    logic [1:0]           k_reg  [0:N];
    logic                 flip_reg [0:N];
    logic                 zero_reg [0:N];

    logic                 advance, em_load;
    logic                 em_valid_reg, em_phase_reg;
    logic [1:0]           em_k_reg;
    logic signed [OW-1:0] em_cx_reg, em_cy_reg, em_ex_reg, em_ey_reg;

    logic signed [RW-1:0] rxf, ryf;
    logic signed [63:0]   ex, ey;

    assign em_load = !em_valid_reg || (em_phase_reg && m_ready);
    assign advance = !st_valid_reg[N] || em_load;
    assign q_pop   = advance && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg[0] <= 1'b0;
        end else if (advance) begin
            st_valid_reg[0] <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            {zero_reg[0], flip_reg[0], k_reg[0], rx_reg[0], y_reg[0], x_reg[0],
             py_reg[0], px_reg[0]} <= q_data;
            ry_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_valid_reg[i+1] <= 1'b0;
            end else if (advance) begin
                st_valid_reg[i+1] <= st_valid_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                if (y_reg[i] >= 0) begin
                    x_reg[i+1]  <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1]  <= y_reg[i] - (x_reg[i] >>> i);
                    rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> i);
                end else begin
                    x_reg[i+1]  <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1]  <= y_reg[i] + (x_reg[i] >>> i);
                    rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> i);
                end
                px_reg[i+1]   <= px_reg[i];
                py_reg[i+1]   <= py_reg[i];
                k_reg[i+1]    <= k_reg[i];
                flip_reg[i+1] <= flip_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // light on the corner pushes along minus x
    always_comb begin
        rxf = flip_reg[N] ? -rx_reg[N] : rx_reg[N];
        ryf = flip_reg[N] ? -ry_reg[N] : ry_reg[N];
        if (zero_reg[N]) begin
            ex = -(64'(extension_length) <<< FRAC_BITS);
            ey = '0;
        end else begin
            ex = rrsp_pkg::round_shift(64'(rxf), rrsp_pkg::EXT_BITS);
            ey = rrsp_pkg::round_shift(64'(ryf), rrsp_pkg::EXT_BITS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
            em_phase_reg <= 1'b0;
        end else if (em_load) begin
            em_valid_reg <= st_valid_reg[N];
            em_phase_reg <= 1'b0;
        end else if (m_ready) begin
            em_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (em_load) begin
            em_k_reg  <= k_reg[N];
            em_cx_reg <= rrsp_pkg::sat_out(64'(px_reg[N]));
            em_cy_reg <= rrsp_pkg::sat_out(64'(py_reg[N]));
            em_ex_reg <= rrsp_pkg::sat_out(64'(px_reg[N]) + ex);
            em_ey_reg <= rrsp_pkg::sat_out(64'(py_reg[N]) + ey);
        end
    end

    assign m_valid    = em_valid_reg;
    assign m_vertex_x = em_phase_reg ? em_ex_reg : em_cx_reg;
    assign m_vertex_y = em_phase_reg ? em_ey_reg : em_cy_reg;
    assign m_corner   = em_k_reg;
    assign m_extended = em_phase_reg;
    assign m_last     = em_phase_reg && (em_k_reg == 2'd3);

    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (em_valid_reg && !em_phase_reg && m_ready) |=> (em_valid_reg && em_phase_reg))
        else $error("pushed vertex did not follow its corner");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg[N] && !advance) |=> st_valid_reg[N])
        else $error("stalled cordic result lost");

endmodule

>>> rtl/rotated_rect_shadow_projection.sv
// top level: apb registers, corner front end, job queue and cordic back end
//
// Each light position accepted on the input stream yields eight vertices of the
// shadow strip: per corner, in order 0..3, the corner and then the corner pushed
// away from the light, with tlast on the eighth. The result stream carries one
// vertex per cycle when results are taken at once; the output stage sends two
// vertices per cordic result. First vertices of an item pass through the corner
// pipeline, the queue and one cordic stage per step before they appear. The
// corner front end runs ahead through an eight-entry queue, so a new light
// position is taken while earlier vertices are still being sent. Registers
// should be written through the apb port only while the block is idle; the
// block itself does not enforce this.
module rotated_rect_shadow_projection #(
    parameter int FRAC_BITS    = 4,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // light_x[15:0], light_y[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // vertex_x[25:0], vertex_y[51:26], zero pad
    output logic [2:0]  m_axis_tuser,   // corner_number[1:0], is_extended[2]
    output logic        m_axis_tlast
);
    localparam int JW    = 2 * (20 + FRAC_BITS) + 2 * (47 + FRAC_BITS) + (31 + FRAC_BITS) + 4;
    localparam int CNT_W = $clog2(rrsp_pkg::Q_DEPTH + 1);
    localparam int OW    = rrsp_pkg::OUT_W;

    logic signed [15:0] center_x_reg, center_y_reg;
    logic [15:0]        width_reg, height_reg;
    logic [8:0]         rotation_reg;
    logic [19:0]        extension_reg;
    logic               wr_en;

    logic               push_valid, q_valid, q_pop;
    logic [JW-1:0]      push_data, q_data;
    logic [CNT_W-1:0]   q_count;
    logic signed [OW-1:0] vx, vy;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            rotation_reg  <= '0;
            extension_reg <= 20'd100000;
        end else if (wr_en) begin
            unique case (paddr[4:2])
                rrsp_pkg::REG_CENTER_X:  center_x_reg  <= pwdata[15:0];
                rrsp_pkg::REG_CENTER_Y:  center_y_reg  <= pwdata[15:0];
                rrsp_pkg::REG_WIDTH:     width_reg     <= pwdata[15:0];
                rrsp_pkg::REG_HEIGHT:    height_reg    <= pwdata[15:0];
                rrsp_pkg::REG_ROTATION:  rotation_reg  <= pwdata[8:0];
                rrsp_pkg::REG_EXTENSION: extension_reg <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            rrsp_pkg::REG_CENTER_X:  prdata = 32'(center_x_reg);
            rrsp_pkg::REG_CENTER_Y:  prdata = 32'(center_y_reg);
            rrsp_pkg::REG_WIDTH:     prdata = 32'(width_reg);
            rrsp_pkg::REG_HEIGHT:    prdata = 32'(height_reg);
            rrsp_pkg::REG_ROTATION:  prdata = 32'(rotation_reg);
            rrsp_pkg::REG_EXTENSION: prdata = 32'(extension_reg);
            default:                 prdata = '0;
        endcase
    end

    rrsp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_axis_tvalid),
        .s_ready          (s_axis_tready),
        .s_light_x        (s_axis_tdata[15:0]),
        .s_light_y        (s_axis_tdata[31:16]),
        .center_x         (center_x_reg),
        .center_y         (center_y_reg),
        .rect_width       (width_reg),
        .rect_height      (height_reg),
        .rotation_deg     (rotation_reg),
        .extension_length (extension_reg),
        .q_count          (q_count),
        .push_valid       (push_valid),
        .push_data        (push_data)
    );

    rrsp_queue #(.WIDTH(JW), .DEPTH(rrsp_pkg::Q_DEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop        (q_pop),
        .out_valid  (q_valid),
        .out_data   (q_data),
        .count      (q_count)
    );

    rrsp_back #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_data           (q_data),
        .q_pop            (q_pop),
        .extension_length (extension_reg),
        .m_valid          (m_axis_tvalid),
        .m_ready          (m_axis_tready),
        .m_vertex_x       (vx),
        .m_vertex_y       (vy),
        .m_corner         (m_axis_tuser[1:0]),
        .m_extended       (m_axis_tuser[2]),
        .m_last           (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, vy, vx};

    a_last_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == 3'b111))
        else $error("tlast on a vertex other than the eighth");

endmodule

>>> test/tb_rotated_rect_shadow_projection.sv
// self-checking testbench for the rotated rectangle shadow projection block
`timescale 1ns / 100ps

module tb_rotated_rect_shadow_projection;

    localparam int FRAC = 4;
    localparam int STEPS = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;
    localparam longint OUT_HI = (64'sd1 <<< 25) - 1;
    localparam longint OUT_LO = -(64'sd1 <<< 25);

    typedef struct packed {
        logic signed [25:0] vx;
        logic signed [25:0] vy;
        logic [1:0]         corner;
        logic               pushed;
        logic               last;
    } vertex_t;

    typedef struct {
        bit          has_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        logic [15:0] lx;
        logic [15:0] ly;
        bit          has_known;
        vertex_t     known0;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // light_x[15:0], light_y[31:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // vertex_x[25:0], vertex_y[51:26], zero pad
    logic [2:0]  m_axis_tuser;        // corner_number[1:0], is_extended[2]
    logic        m_axis_tlast;

    // shadow copy of the register file
    logic [15:0] cfg_cx = 0, cfg_cy = 0, cfg_w = 0, cfg_h = 0;
    logic [8:0]  cfg_rot = 0;
    logic [19:0] cfg_len = 20'd100000;

    vertex_t vertex_queue[$];
    vertex_t known_queue[$];   // typed-in expected first vertex, or none
    bit      known_valid[$];
    int      errors = 0;
    int      items_sent = 0;
    int      vertices_seen = 0;
    int      idle_cycles = 0;
    bit      hold_off = 1'b0;

    rotated_rect_shadow_projection dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint round_away(longint v, int sh);
        longint half;
        half = 64'sd1 <<< (sh - 1);
        if (v < 0) return -((-v + half) >>> sh);
        return (v + half) >>> sh;
    endfunction

    function automatic longint sin_table(int d);
        int q;
        q = (d <= 90) ? d : (d <= 180) ? 180 - d : (d <= 270) ? d - 180 : 360 - d;
        return (d <= 180) ? longint'(rrsp_pkg::sin_q15(7'(q)))
                          : -longint'(rrsp_pkg::sin_q15(7'(q)));
    endfunction

    function automatic logic signed [25:0] clamp26(longint v);
        if (v > OUT_HI) return OUT_HI[25:0];
        if (v < OUT_LO) return OUT_LO[25:0];
        return v[25:0];
    endfunction

    // computes the eight strip vertices for one light position
    task automatic project_shadow(logic [15:0] lx_in, logic [15:0] ly_in);
        longint one, s, c, cx, cy, w, h, lx, ly, len;
        longint sx, sy, px, py, vx, vy, ex, ey, bx, by, rx, ry, nbx, nby, nrx, nry;
        int deg;
        bit flip;
        vertex_t v;
        one = 64'sd1 <<< FRAC;
        deg = cfg_rot % 360;
        s = sin_table(deg);
        c = sin_table((deg + 90) % 360);
        cx = longint'($signed(cfg_cx)) * one;
        cy = longint'($signed(cfg_cy)) * one;
        w = cfg_w;
        h = cfg_h;
        lx = longint'($signed(lx_in)) * one;
        ly = longint'($signed(ly_in)) * one;
        len = longint'(cfg_len) * one;
        for (int k = 0; k < 4; k++) begin
            sx = (k == 0 || k == 3) ? 1 : -1;
            sy = (k < 2) ? 1 : -1;
            px = cx + round_away((sx * w * c - sy * h * s) * one, 16);
            py = cy + round_away((sx * w * s + sy * h * c) * one, 16);
            vx = px - lx;
            vy = py - ly;
            if (vx == 0 && vy == 0) begin
                // light sitting on the corner pushes straight along -x
                ex = -len;
                ey = 0;
            end else begin
                flip = vx < 0;
                if (flip) begin
                    vx = -vx;
                    vy = -vy;
                end
                bx = vx <<< rrsp_pkg::VEC_SHIFT;
                by = vy <<< rrsp_pkg::VEC_SHIFT;
                rx = round_away(len * rrsp_pkg::KINV_Q30, 30 - rrsp_pkg::EXT_BITS);
                ry = 0;
                for (int i = 0; i < STEPS; i++) begin
                    if (by >= 0) begin
                        nbx = bx + (by >>> i);
                        nby = by - (bx >>> i);
                        nrx = rx - (ry >>> i);
                        nry = ry + (rx >>> i);
                    end else begin
                        nbx = bx - (by >>> i);
                        nby = by + (bx >>> i);
                        nrx = rx + (ry >>> i);
                        nry = ry - (rx >>> i);
                    end
                    bx = nbx; by = nby; rx = nrx; ry = nry;
                end
                if (flip) begin
                    rx = -rx;
                    ry = -ry;
                end
                ex = round_away(rx, rrsp_pkg::EXT_BITS);
                ey = round_away(ry, rrsp_pkg::EXT_BITS);
            end
            v = '{clamp26(px), clamp26(py), 2'(k), 1'b0, 1'b0};
            vertex_queue.push_back(v);
            v = '{clamp26(px + ex), clamp26(py + ey), 2'(k), 1'b1, k == 3};
            vertex_queue.push_back(v);
        end
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            rrsp_pkg::REG_CENTER_X:  cfg_cx = val[15:0];
            rrsp_pkg::REG_CENTER_Y:  cfg_cy = val[15:0];
            rrsp_pkg::REG_WIDTH:     cfg_w = val[15:0];
            rrsp_pkg::REG_HEIGHT:    cfg_h = val[15:0];
            rrsp_pkg::REG_ROTATION:  cfg_rot = val[8:0];
            rrsp_pkg::REG_EXTENSION: cfg_len = val[19:0];
            default: ;
        endcase
    endtask

    // waits for the strip to drain, then the pipeline tail
    task automatic wait_idle();
        while (vertex_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_light(logic [15:0] lx, logic [15:0] ly, bit known_ok, vertex_t kv);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {ly, lx};
        project_shadow(lx, ly);
        known_valid.push_back(known_ok);
        known_queue.push_back(kv);
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic end_burst();
        s_axis_tvalid <= 1'b0;
    endtask

    // receiver side: random stalls, one long hold-off on request
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
            if ($urandom_range(0, 2) == 0) stall = 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // result checker
    always @(posedge aclk) begin
        vertex_t got, exp_v;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[25:0], m_axis_tdata[51:26], m_axis_tuser[1:0],
                    m_axis_tuser[2], m_axis_tlast};
            vertices_seen++;
            if (vertex_queue.size() == 0) begin
                $display("%0t: unexpected vertex %p", $time, got);
                errors++;
            end else begin
                exp_v = vertex_queue.pop_front();
                if (exp_v.corner == 0 && !exp_v.pushed) begin
                    if (known_valid.pop_front()) begin
                        exp_v = known_queue.pop_front();
                    end else begin
                        void'(known_queue.pop_front());
                    end
                end
                if (got.vx !== exp_v.vx || got.vy !== exp_v.vy) begin
                    $display("%0t: vertex xy expected %0d,%0d got %0d,%0d", $time,
                             exp_v.vx, exp_v.vy, got.vx, got.vy);
                    errors++;
                end
                if (got.corner !== exp_v.corner || got.pushed !== exp_v.pushed) begin
                    $display("%0t: corner/pushed expected %0d/%0d got %0d/%0d", $time,
                             exp_v.corner, exp_v.pushed, got.corner, got.pushed);
                    errors++;
                end
                if (got.last !== exp_v.last) begin
                    $display("%0t: tlast expected %0b got %0b", $time, exp_v.last, got.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_rotated_rect_shadow_projection failed");
            $finish;
        end
    end

    stim_row_t directed[$];

    function automatic stim_row_t row_cfg(logic [2:0] idx, logic [31:0] val);
        stim_row_t r;
        r = '{1'b1, idx, val, 16'd0, 16'd0, 1'b0, vertex_t'(0)};
        return r;
    endfunction

    function automatic stim_row_t row_light(logic [15:0] lx, logic [15:0] ly);
        stim_row_t r;
        r = '{1'b0, 3'd0, 32'd0, lx, ly, 1'b0, vertex_t'(0)};
        return r;
    endfunction

    function automatic stim_row_t row_known(logic [15:0] lx, logic [15:0] ly, vertex_t kv);
        stim_row_t r;
        r = row_light(lx, ly);
        r.has_known = 1'b1;
        r.known0 = kv;
        return r;
    endfunction

    initial begin
        stim_row_t r;
        logic [15:0] lx, ly;
        int phase;
        // after reset the rectangle is a point at the origin
        directed.push_back(row_known(16'd5, 16'd7, '{26'sd0, 26'sd0, 2'd0, 1'b0, 1'b0}));
        directed.push_back(row_light(16'd0, 16'd0));        // light on every corner
        directed.push_back(row_light(16'h8000, 16'h7FFF));
        directed.push_back(row_light(16'h7FFF, 16'h8000));
        directed.push_back(row_cfg(rrsp_pkg::REG_WIDTH, 32'd200));
        directed.push_back(row_cfg(rrsp_pkg::REG_HEIGHT, 32'd100));
        directed.push_back(row_cfg(rrsp_pkg::REG_ROTATION, 32'd0));
        directed.push_back(row_known(16'd0, 16'd0, '{26'sd1600, 26'sd800, 2'd0, 1'b0, 1'b0}));
        directed.push_back(row_light(16'd100, 16'd50));     // light on corner 0
        directed.push_back(row_light(16'hFF9C, 16'hFFCE));  // light on corner 2
        directed.push_back(row_cfg(rrsp_pkg::REG_ROTATION, 32'd90));
        directed.push_back(row_light(16'd3, 16'hFFF0));
        directed.push_back(row_cfg(rrsp_pkg::REG_ROTATION, 32'd359));
        directed.push_back(row_light(16'h1234, 16'h8001));
        directed.push_back(row_cfg(rrsp_pkg::REG_ROTATION, 32'd511)); // wraps modulo 360
        directed.push_back(row_light(16'd40, 16'd40));
        directed.push_back(row_cfg(rrsp_pkg::REG_CENTER_X, 32'h7FFF));
        directed.push_back(row_cfg(rrsp_pkg::REG_CENTER_Y, 32'h8000));
        directed.push_back(row_cfg(rrsp_pkg::REG_WIDTH, 32'hFFFF));
        directed.push_back(row_cfg(rrsp_pkg::REG_HEIGHT, 32'hFFFF));
        directed.push_back(row_cfg(rrsp_pkg::REG_EXTENSION, 32'hFFFFF));
        directed.push_back(row_light(16'h8000, 16'h7FFF));  // extreme centre, size and extension
        directed.push_back(row_cfg(rrsp_pkg::REG_EXTENSION, 32'd0));
        directed.push_back(row_light(16'h7FFF, 16'h7FFF));
        directed.push_back(row_cfg(3'd7, 32'hFFFFFFFF));    // unmapped register

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            r = directed[i];
            if (r.has_cfg) begin
                end_burst();
                wait_idle();
                apb_write(r.reg_idx, r.reg_val);
            end else begin
                send_light(r.lx, r.ly, r.has_known, r.known0);
            end
        end
        end_burst();
        wait_idle();

        for (phase = 0; phase < 8; phase++) begin
            if (phase == 1) begin
                apb_write(rrsp_pkg::REG_CENTER_X, 32'h8000);
                apb_write(rrsp_pkg::REG_CENTER_Y, 32'h7FFF);
                apb_write(rrsp_pkg::REG_EXTENSION, 32'd1);
            end else if (phase == 2) begin
                apb_write(rrsp_pkg::REG_WIDTH, 32'd0);
                apb_write(rrsp_pkg::REG_HEIGHT, 32'd0);
                apb_write(rrsp_pkg::REG_EXTENSION, 32'd100000);
            end else if (phase > 2) begin
                apb_write(rrsp_pkg::REG_CENTER_X, $urandom_range(0, 65535));
                apb_write(rrsp_pkg::REG_CENTER_Y, $urandom_range(0, 65535));
                apb_write(rrsp_pkg::REG_WIDTH, (phase % 2) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 400));
                apb_write(rrsp_pkg::REG_HEIGHT, (phase % 2) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 400));
                apb_write(rrsp_pkg::REG_ROTATION, $urandom_range(0, 511));
                apb_write(rrsp_pkg::REG_EXTENSION, $urandom_range(0, 1048575));
            end
            if (phase == 4) hold_off = 1'b1;
            for (int n = 0; n < 30; n++) begin
                case ($urandom_range(0, 4))
                    0: begin
                        lx = $urandom;
                        ly = $urandom;
                    end
                    1: begin
                        // near the rectangle centre, on a corner when the rectangle is a point
                        lx = cfg_cx + 16'($signed($urandom_range(0, 8)) - 4);
                        ly = cfg_cy + 16'($signed($urandom_range(0, 8)) - 4);
                    end
                    default: begin
                        lx = cfg_cx + 16'($urandom_range(0, 2000)) - 16'd1000;
                        ly = cfg_cy + 16'($urandom_range(0, 2000)) - 16'd1000;
                    end
                endcase
                send_light(lx, ly, 1'b0, vertex_t'(0));
                if (n == 15 && phase == 5) begin
                    // sender waits for the block to drain completely
                    end_burst();
                    while (vertex_queue.size() != 0) @(posedge aclk);
                end
            end
            end_burst();
            wait_idle();
        end

        $display("covered %0d light positions and %0d vertices over all registers,",
                 items_sent, vertices_seen);
        $display("extremes, wrapped rotation, lights on corners and saturation");
        if (errors == 0 && vertex_queue.size() == 0) begin
            $display("tb_rotated_rect_shadow_projection passed");
        end else begin
            $display("tb_rotated_rect_shadow_projection failed");
        end
        $finish;
    end

endmodule
